// ===== sv/clt_pkg.sv =====
// Shared types, constants and codes for the compacting list table.
`default_nettype none

package clt_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_DEL_POS = 3'd1,
    REQ_DEL_VAL = 3'd2,
    REQ_FIND    = 3'd3,
    REQ_CLEAR   = 3'd4
  } clt_req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } clt_status_t;

  // Broadcast to every cell for the item being executed.
  typedef struct packed {
    logic                 en;
    logic                 app;
    logic                 del_pos;
    logic                 del_val;
    logic [WORD_BITS-1:0] val;
    logic [IDX_W-1:0]     pos_idx;
    logic [CNT_W-1:0]     len;
  } clt_cmd_t;

  // Passed from cell to cell, lowest index first.
  typedef struct packed {
    logic             seen;
    logic             shift;
    logic [CNT_W-1:0] found;
  } clt_link_t;

endpackage

`default_nettype wire

// ===== sv/clt_cell.sv =====
// One list entry: holds a word, compares it and passes match/shift state on.
`default_nettype none

module clt_cell
  import clt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [IDX_W-1:0]     cell_idx,
  input  wire clt_cmd_t             cmd,
  input  wire logic [WORD_BITS-1:0] next_data,
  input  wire clt_link_t            link_in,
  output clt_link_t                 link_out,
  output logic [WORD_BITS-1:0]      data
);

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;
  logic [CNT_W-1:0]     idx_c;
  logic                 live;
  logic                 match;
  logic                 first;
  logic                 target;

  assign idx_c  = CNT_W'(cell_idx);
  assign live   = idx_c < cmd.len;
  assign match  = live && (data_r == cmd.val);
  assign first  = match && !link_in.seen;
  assign target = (cmd.del_pos && (cell_idx == cmd.pos_idx)) || (cmd.del_val && first);

  assign link_out.seen  = link_in.seen | match;
  assign link_out.shift = link_in.shift | target;
  assign link_out.found = first ? (idx_c + CNT_W'(1)) : link_in.found;

  always_comb begin
    data_nxt = data_r;
    if (cmd.en) begin
      if (link_out.shift) begin
        // close the gap: take the neighbor's word
        data_nxt = next_data;
      end else if (cmd.app && (idx_c == cmd.len)) begin
        data_nxt = cmd.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== sv/compacting_list_table_top.sv =====
// Top level of the compacting list table: request decode, cell row, result register.
//
//  channel | direction | tdata (low bit first)                  | tuser
//  --------+-----------+----------------------------------------+------------------
//  in_     | in        | item_value[31:0], position[36:32], pad | req_type[2:0]
//  out_    | out       | found_position[4:0], entry_count[9:5]  | status[1:0]
//
// Every item is done in one pass: the whole row of cells compares, picks the first
// match through the cell-to-cell link and shifts in that same cycle, so the
// chain of DEPTH cells sets the path length.
// An item is taken whenever the result register is empty or being drained.
// Reset (rst_n low, synchronous) empties the list and the result register;
// stored words are not cleared, the count alone marks them valid.
// A stall on out_ holds the result and blocks in_ until it is taken.
`default_nettype none

module compacting_list_table_top
  import clt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // item_value[31:0], position[36:32], zero pad
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // found_position[4:0], entry_count[9:5], zero pad
  output logic [1:0]       out_tuser   // status[1:0]
);

  // ---------------------------------------------------------------- request
  logic                 accept;
  clt_req_t             req;
  logic [31:0]          in_value;
  logic [4:0]           in_pos;
  logic [CNT_W-1:0]     len_r;
  logic [CNT_W-1:0]     len_nxt;
  logic                 full;
  logic                 pos_ok;
  logic                 hit;
  clt_cmd_t             cmd;

  assign accept   = in_tvalid && in_tready;
  assign req      = clt_req_t'(in_tuser);
  assign in_value = in_tdata[31:0];
  assign in_pos   = in_tdata[36:32];

  assign full   = (32'(len_r) >= 32'(DEPTH));
  assign pos_ok = (in_pos != 5'd0) && (32'(in_pos) <= 32'(len_r));

  // ---------------------------------------------------------------- cell row
  clt_link_t            links [DEPTH+1];
  logic [WORD_BITS-1:0] words [DEPTH];

  assign links[0] = '0;

  always_comb begin
    cmd         = '0;
    cmd.en      = accept;
    cmd.app     = (req == REQ_APPEND) && !full;
    cmd.del_pos = (req == REQ_DEL_POS) && pos_ok;
    cmd.del_val = (req == REQ_DEL_VAL);
    cmd.val     = WORD_BITS'(in_value);
    cmd.pos_idx = IDX_W'(in_pos - 5'd1);
    cmd.len     = len_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = words[i+1];
    end else begin : g_end
      // last entry has no right neighbor; its word is dropped by the count
      assign nbr = words[i];
    end
    clt_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(i)),
      .cmd       (cmd),
      .next_data (nbr),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .data      (words[i])
    );
  end

  assign hit = links[DEPTH].seen;

  // ---------------------------------------------------------------- result
  clt_status_t          status;
  logic [CNT_W-1:0]     found;

  always_comb begin
    status  = ST_OK;
    found   = '0;
    len_nxt = len_r;
    unique case (req)
      REQ_APPEND: begin
        if (full) status = ST_FULL;
        else      len_nxt = len_r + CNT_W'(1);
      end
      REQ_DEL_POS: begin
        if (pos_ok) len_nxt = len_r - CNT_W'(1);
        else        status  = ST_BAD_POS;
      end
      REQ_DEL_VAL: begin
        found = links[DEPTH].found;
        if (hit) len_nxt = len_r - CNT_W'(1);
        else     status  = ST_NOT_FOUND;
      end
      REQ_FIND: begin
        found = links[DEPTH].found;
        if (!hit) status = ST_NOT_FOUND;
      end
      REQ_CLEAR: begin
        len_nxt = '0;
      end
      default: begin
        // unused kinds: report ok, leave the list alone
      end
    endcase
  end

  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [4:0]        found_r;
  logic [4:0]        count_r;

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: load with each accepted item, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      found_r  <= 5'(found);
      count_r  <= 5'(len_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'd0, count_r, found_r};

  // ---------------------------------------------------------------- checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= 32'(DEPTH))
    else $error("list length exceeds depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FULL)) |-> (32'(out_tdata[9:5]) == 32'(DEPTH)))
    else $error("full status with list not full");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_NOT_FOUND)) |-> (out_tdata[4:0] == 5'd0))
    else $error("miss reports a position");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req == REQ_APPEND) && !full) |=> (len_r == $past(len_r) + CNT_W'(1)))
    else $error("append did not grow the list");

endmodule

`default_nettype wire
